### design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is asserted.
`define RMST_CHECK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// Clocked check that also holds during reset.
`define RMST_CHECK_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/rmst_pkg.sv
`timescale 1ns / 1ps

package rmst_pkg;

	localparam int NODE_W     = 32;
	localparam int POS_W      = 10;
	localparam int RANGE_W    = 11;
	localparam int LEAVES_DEF = 1024;

	localparam logic signed [NODE_W-1:0] NODE_IDENT = 32'sh7FFF_FFFF;

	localparam logic KIND_UPDATE = 1'b0;
	localparam logic KIND_QUERY  = 1'b1;

	typedef logic signed [NODE_W-1:0] node_t;

	// signed minimum
	function automatic node_t smin(input node_t a, input node_t b);
		return (a <= b) ? a : b;
	endfunction

endpackage

### design/range_min_segment_tree.sv
`timescale 1ns / 1ps

// Channel | Handshake          | Payload
// --------+--------------------+-------------------------------------------------
// in      | in_valid/in_ready  | kind, position, update_value, range_lo, range_hi
// out     | out_valid/out_ready| min_value (queries only)
//
// After reset a clearing pass writes the identity to all 2*LEAVES nodes, one a cycle;
//   in_ready stays low until the pass is done.
// Update: one tree level a cycle, set by the sibling reads on RAM port A; an update whose
//   position lies beyond the leaves is dropped and the tree is not written.
// Query: one level a cycle over both RAM read ports plus a two-stage fold into the
//   accumulator.
// The result sits in an output register; a stalled out channel holds only the final
//   cycle of the next query.
module range_min_segment_tree #(
	parameter int LEAVES = rmst_pkg::LEAVES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              kind,
	input  logic [rmst_pkg::POS_W-1:0]        position,
	input  logic signed [rmst_pkg::NODE_W-1:0] update_value,
	input  logic [rmst_pkg::RANGE_W-1:0]      range_lo,
	input  logic [rmst_pkg::RANGE_W-1:0]      range_hi,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [rmst_pkg::NODE_W-1:0] min_value
);

	// node index: leaf i lives at LEAVES + i, root at 1
	localparam int NW    = $clog2(LEAVES) + 1;
	localparam int QW    = NW + 1;              // query bounds reach 2*LEAVES
	localparam int DEPTH = 2 * LEAVES;
	localparam logic [31:0] LEAVES_U = 32'(LEAVES);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_UPD   = 2'd2;
	localparam logic [1:0] ST_QRY   = 2'd3;

	logic [1:0]    state_q;
	logic [NW-1:0] clr_q;
	logic          first_q;

	// update walk
	logic [NW-1:0] leaf_q;
	logic [NW-1:0] iss_q;
	logic          upd_pend_s1;
	logic [NW-1:0] par_s1;

	// query walk
	logic [QW-1:0] lo_q;
	logic [QW-1:0] hi_q;
	logic          q_vld_s1;
	logic          q_ena_s1;
	logic          q_enb_s1;
	logic          q_vld_s2;
	rmst_pkg::node_t q_min_s2;

	rmst_pkg::node_t acc_q;
	logic            out_valid_q;
	rmst_pkg::node_t out_q;

	// RAM ports
	logic            mem_we;
	logic [NW-1:0]   mem_waddr;
	rmst_pkg::node_t mem_wdata;
	logic [NW-1:0]   ra_addr;
	logic [NW-1:0]   rb_addr;
	logic [rmst_pkg::NODE_W-1:0] ra_data;
	logic [rmst_pkg::NODE_W-1:0] rb_data;

	logic        in_xfer;
	logic        pos_ok;
	logic [31:0] hi_clip;
	logic        q_empty;
	logic [NW-1:0] leaf_idx;
	logic [QW-1:0] lo_init;
	logic [QW-1:0] hi_init;
	logic        upd_iss;
	logic        q_iss;
	logic        q_done;
	logic        out_free;
	rmst_pkg::node_t upd_min;
	rmst_pkg::node_t qa_val;
	rmst_pkg::node_t qb_val;

	assign in_ready = (state_q == ST_IDLE);
	assign in_xfer  = in_valid && in_ready;

	// decode of the incoming item
	assign pos_ok   = 32'(position) < LEAVES_U;
	assign hi_clip  = (32'(range_hi) > LEAVES_U) ? LEAVES_U : 32'(range_hi);
	assign q_empty  = 32'(range_lo) >= hi_clip;
	assign leaf_idx = NW'(LEAVES_U + 32'(position));
	assign lo_init  = QW'(LEAVES_U + 32'(range_lo));
	assign hi_init  = QW'(LEAVES_U + hi_clip);

	// update issues one sibling read per level until the root is reached
	assign upd_iss = (state_q == ST_UPD) && (iss_q[NW-1:1] != '0);
	// query issues one level per cycle while the bounds have not met
	assign q_iss   = (state_q == ST_QRY) && (lo_q < hi_q);
	assign q_done  = (state_q == ST_QRY) && !q_iss && !q_vld_s1 && !q_vld_s2;
	assign out_free = !out_valid_q || out_ready;

	assign upd_min = rmst_pkg::smin(acc_q, rmst_pkg::node_t'(ra_data));
	assign qa_val  = q_ena_s1 ? rmst_pkg::node_t'(ra_data) : rmst_pkg::NODE_IDENT;
	assign qb_val  = q_enb_s1 ? rmst_pkg::node_t'(rb_data) : rmst_pkg::NODE_IDENT;

	// read addresses: sibling on an update, odd bounds on a query
	assign ra_addr = (state_q == ST_UPD) ? (iss_q ^ NW'(1)) : lo_q[NW-1:0];
	assign rb_addr = NW'(hi_q - QW'(1));

	// write port: clearing pass, leaf write, or recomputed parent
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = clr_q;
		mem_wdata = rmst_pkg::NODE_IDENT;
		if (state_q == ST_CLEAR) begin
			mem_we = 1'b1;
		end else if (state_q == ST_UPD && first_q) begin
			mem_we    = 1'b1;
			mem_waddr = leaf_q;
			mem_wdata = acc_q;
		end else if (state_q == ST_UPD && upd_pend_s1) begin
			mem_we    = 1'b1;
			mem_waddr = par_s1;
			mem_wdata = upd_min;
		end
	end

	rmst_ram #(
		.WIDTH (rmst_pkg::NODE_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (mem_waddr),
		.wdata   (mem_wdata),
		.ra_addr (ra_addr),
		.ra_data (ra_data),
		.rb_addr (rb_addr),
		.rb_data (rb_data)
	);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			first_q     <= 1'b0;
			upd_pend_s1 <= 1'b0;
			q_vld_s1    <= 1'b0;
			q_vld_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			upd_pend_s1 <= upd_iss;
			q_vld_s1    <= q_iss;
			q_vld_s2    <= q_vld_s1;
			first_q     <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + NW'(1);
					if (clr_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_xfer) begin
						if (kind == rmst_pkg::KIND_QUERY) begin
							state_q <= ST_QRY;
						end else if (pos_ok) begin
							state_q <= ST_UPD;
							first_q <= 1'b1;
						end
					end
				end
				ST_UPD: begin
					// last combine writes the root
					if (upd_pend_s1 && par_s1 == NW'(1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_QRY: begin
					if (q_done && out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (q_done && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			leaf_q <= leaf_idx;
			iss_q  <= leaf_idx;
			acc_q  <= (kind == rmst_pkg::KIND_UPDATE) ? update_value : rmst_pkg::NODE_IDENT;
			lo_q   <= q_empty ? '0 : lo_init;
			hi_q   <= q_empty ? '0 : hi_init;
		end
		if (upd_iss) begin
			iss_q  <= iss_q >> 1;
			par_s1 <= iss_q >> 1;
		end
		if (state_q == ST_UPD && upd_pend_s1) begin
			acc_q <= upd_min;
		end
		if (q_iss) begin
			lo_q     <= (lo_q + QW'(lo_q[0])) >> 1;
			hi_q     <= hi_q >> 1;
			q_ena_s1 <= lo_q[0];
			q_enb_s1 <= hi_q[0];
		end
		q_min_s2 <= rmst_pkg::smin(qa_val, qb_val);
		if (state_q == ST_QRY && q_vld_s2) begin
			acc_q <= rmst_pkg::smin(acc_q, q_min_s2);
		end
		if (q_done && out_free) begin
			out_q <= acc_q;
		end
	end

	assign out_valid = out_valid_q;
	assign min_value = out_q;

endmodule

### design/rmst_ram.sv
`timescale 1ns / 1ps

// One write port, two registered read ports.
module rmst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    ra_addr,
	output logic [WIDTH-1:0] ra_data,
	input  logic [AW-1:0]    rb_addr,
	output logic [WIDTH-1:0] rb_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		ra_data <= mem[ra_addr];
		rb_data <= mem[rb_addr];
	end

endmodule

### design/rmst_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rmst_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_ready,
	input logic                               kind,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic signed [rmst_pkg::NODE_W-1:0] min_value
);

	`RMST_CHECK(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid, "result dropped before transfer")
	`RMST_CHECK(a_out_stable, clk, arst_n, out_valid && !out_ready |=> $stable(min_value), "stalled result changed")
	`RMST_CHECK(a_query_busy, clk, arst_n, in_valid && in_ready && kind == rmst_pkg::KIND_QUERY |=> !in_ready, "query transfer did not occupy the tree walk")
	`RMST_CHECK(a_result_frees, clk, arst_n, $rose(out_valid) |-> in_ready, "result posted while the walk was still busy")
	`RMST_CHECK_ALWAYS(a_reset_quiet, clk, !arst_n |-> !out_valid && !in_ready, "handshake active in reset")

endmodule

bind range_min_segment_tree rmst_checker u_rmst_checker (.*);
